[rtl/tle_pkg.sv]
// Package for the terminal line editor: key codes, result record type and
// stream widths. No dependencies; used by every module of the block.
`default_nettype none

package tle_pkg;

  localparam int LINE_BUFFER_SIZE_DEF = 32;
  localparam int RES_MAX              = 3;
  localparam int RES_IDX_W            = 2;
  localparam int IDX_W                = 5;
  localparam int IN_DATA_W            = 8;
  localparam int OUT_DATA_W           = 32;
  localparam int OUT_USER_W           = 3;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_TICK  = 8'd96;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;

  typedef struct packed {
    logic             echo_valid;
    logic [7:0]       echo_byte;
    logic             store_valid;
    logic [IDX_W-1:0] store_index;
    logic [7:0]       store_byte;
    logic             line_done;
    logic [IDX_W-1:0] line_length;
    logic             term_debug;
    logic             adc_debug;
  } tle_result_t;

  typedef tle_result_t tle_burst_t [RES_MAX];

endpackage

`default_nettype wire

[rtl/tle_decode.sv]
// Key decoder of the terminal line editor: turns one byte and the editor state
// into up to three results and the next state. Depends on tle_pkg.
`default_nettype none

module tle_decode
  import tle_pkg::*;
#(
  parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF,
  localparam int PosW = $clog2(LINE_BUFFER_SIZE)
) (
  input  wire logic [7:0]           rx_byte,
  input  wire logic [PosW-1:0]      pos,
  input  wire logic                 term_dbg,
  input  wire logic                 adc_dbg,
  output tle_burst_t                res,
  output logic [RES_IDX_W-1:0]      res_last,
  output logic [PosW-1:0]           pos_nxt,
  output logic                      term_dbg_nxt,
  output logic                      adc_dbg_nxt
);

  logic [PosW+IDX_W-1:0] pos_ext;
  logic [IDX_W-1:0]      pos_lo;
  logic                  line_full;
  logic                  line_empty;

  assign pos_ext    = {{IDX_W{1'b0}}, pos};
  assign pos_lo     = pos_ext[IDX_W-1:0];
  assign line_full  = (pos == PosW'(LINE_BUFFER_SIZE - 1));
  assign line_empty = (pos == '0);

  always_comb begin
    for (int k = 0; k < RES_MAX; k++) begin
      res[k] = '0;
    end
    res_last     = '0;
    pos_nxt      = pos;
    term_dbg_nxt = term_dbg;
    adc_dbg_nxt  = adc_dbg;

    unique case (rx_byte)
      CH_CR: begin
        res[0].echo_valid  = 1'b1;
        res[0].echo_byte   = CH_CR;
        res[1].echo_valid  = 1'b1;
        res[1].echo_byte   = CH_LF;
        res[1].store_valid = 1'b1;
        res[1].store_index = pos_lo;
        res[1].line_done   = 1'b1;
        res[1].line_length = pos_lo;
        res_last           = RES_IDX_W'(1);
        pos_nxt            = '0;
      end
      CH_BS, CH_DEL: begin
        if (!line_empty) begin
          res[0].echo_valid = 1'b1;
          res[0].echo_byte  = CH_BS;
          res[1].echo_valid = 1'b1;
          res[1].echo_byte  = CH_SP;
          res[2].echo_valid = 1'b1;
          res[2].echo_byte  = CH_BS;
          res_last          = RES_IDX_W'(2);
          pos_nxt           = pos - PosW'(1);
        end
      end
      CH_TILDE: term_dbg_nxt = 1'b1;
      CH_TICK:  term_dbg_nxt = 1'b0;
      CH_TAB: begin
        adc_dbg_nxt        = 1'b1;
        res[0].line_done   = 1'b1;
        res[0].line_length = pos_lo;
      end
      CH_ESC:   adc_dbg_nxt = 1'b0;
      default: begin
        res[0].store_valid = 1'b1;
        res[0].store_index = pos_lo;
        if (line_full) begin
          // terminate and close the line, drop the byte
          res[0].line_done   = 1'b1;
          res[0].line_length = pos_lo;
          pos_nxt            = '0;
        end else begin
          res[0].echo_valid = 1'b1;
          res[0].echo_byte  = rx_byte;
          res[0].store_byte = rx_byte;
          pos_nxt           = pos + PosW'(1);
        end
      end
    endcase

    for (int k = 0; k < RES_MAX; k++) begin
      res[k].term_debug = term_dbg_nxt;
      res[k].adc_debug  = adc_dbg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/tle_out_buf.sv]
// Result register of the terminal line editor: holds the results of one byte
// and hands them out one transfer per cycle while out_tready is high. Depends on tle_pkg.
`default_nettype none

module tle_out_buf
  import tle_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load_valid,
  input  wire tle_burst_t            load_res,
  input  wire logic [RES_IDX_W-1:0]  load_last,
  output logic                       load,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output tle_result_t                out_res,
  output logic                       out_tlast
);

  tle_result_t          buf_r [RES_MAX];
  logic                 busy_r;
  logic [RES_IDX_W-1:0] idx_r;
  logic [RES_IDX_W-1:0] last_r;
  logic                 drain;

  assign out_tvalid = busy_r;
  assign out_tlast  = (idx_r == last_r);
  assign out_res    = buf_r[idx_r];
  assign drain      = busy_r & out_tready & out_tlast;
  // take the next burst when empty or when the final result leaves
  assign load       = load_valid & (~busy_r | drain);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      last_r <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      last_r <= load_last;
    end else if (drain) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_tready) begin
      idx_r <= idx_r + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < RES_MAX; k++) begin
        buf_r[k] <= load_res[k];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/terminal_line_editor.sv]
// Terminal line editor: one received byte in, one to three results out, each
// with echo, line memory write, line completion and debug flag fields. A byte
// is captured in an input register, decoded in one pass against the line
// position and the two debug flags, and its results land in a result register
// that sends one transfer per cycle while out_tready is high. A byte yields
// one result (most keys), two (carriage return) or three (backspace or DEL on
// a non-empty line); the result register sets that pace, and the input
// register takes the next byte while results are still leaving. A byte goes
// through the input register, then the result register, which can stall it.
// Depends on tle_pkg, tle_decode and tle_out_buf.
`default_nettype none

module terminal_line_editor
  import tle_pkg::*;
#(
  parameter int LINE_BUFFER_SIZE = LINE_BUFFER_SIZE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [7:0] echo_byte, [12:8] store_index, [20:13] store_byte,
  // [25:21] line_length, [26] term_debug, [27] adc_debug, [31:28] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] echo_valid, [1] store_valid, [2] line_done
  output logic [OUT_USER_W-1:0]      out_tuser,
  output logic                       out_tlast
);

  localparam int PosW = $clog2(LINE_BUFFER_SIZE);

  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic [PosW-1:0]      pos_r;
  logic                 term_dbg_r;
  logic                 adc_dbg_r;

  tle_burst_t           dec_res;
  logic [RES_IDX_W-1:0] dec_last;
  logic [PosW-1:0]      pos_nxt;
  logic                 term_dbg_nxt;
  logic                 adc_dbg_nxt;
  logic                 load;
  tle_result_t          out_res;

  assign in_tready = ~in_valid_r | load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata[7:0];
    end
  end

  // advance the editor state when a byte's results enter the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      term_dbg_r <= 1'b0;
      adc_dbg_r  <= 1'b0;
    end else if (load) begin
      pos_r      <= pos_nxt;
      term_dbg_r <= term_dbg_nxt;
      adc_dbg_r  <= adc_dbg_nxt;
    end
  end

  tle_decode #(
    .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
  ) u_decode (
    .rx_byte      (in_byte_r),
    .pos          (pos_r),
    .term_dbg     (term_dbg_r),
    .adc_dbg      (adc_dbg_r),
    .res          (dec_res),
    .res_last     (dec_last),
    .pos_nxt      (pos_nxt),
    .term_dbg_nxt (term_dbg_nxt),
    .adc_dbg_nxt  (adc_dbg_nxt)
  );

  tle_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_valid_r),
    .load_res   (dec_res),
    .load_last  (dec_last),
    .load       (load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {4'd0, out_res.adc_debug, out_res.term_debug, out_res.line_length,
                      out_res.store_byte, out_res.store_index, out_res.echo_byte};
  assign out_tuser = {out_res.line_done, out_res.store_valid, out_res.echo_valid};

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosW'(LINE_BUFFER_SIZE - 1))
    else $error("line position beyond buffer");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("line completion on a non-final result");

  a_store_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("line write on a non-final result");

  a_silent_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("result without echo inside a burst");

endmodule

`default_nettype wire
